FILE: rtl/lerb_pkg.sv
package lerb_pkg;

	localparam int RING_DEPTH = 32;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);

	localparam logic [7:0] CODE_BS = 8'd8;
	localparam logic [7:0] CODE_NL = 8'd10;

	typedef enum logic [2:0] {
		KIND_ECHO  = 3'd0,
		KIND_ERASE = 3'd1,
		KIND_WAKE  = 3'd2,
		KIND_RBYTE = 3'd3,
		KIND_REND  = 3'd4,
		KIND_BLOCK = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_T_ECHO,
		ST_T_WAKE,
		ST_R_CHK,
		ST_R_POP,
		ST_R_END
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  accept;
		logic  emit;
		kind_t kind;
		logic  last;
		logic  pop;
		logic  set_wait;
		logic  clr_wait;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic echo_on;
		logic is_bs;
		logic is_nl;
		logic bs_hit;
		logic waiting;
		logic line_avail;
		logic max_zero;
		logic pop_done;
	} dp_status_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(RING_DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

FILE: rtl/lerb_dp.sv
module lerb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd,
	input  logic [7:0]          char_in,
	input  logic [6:0]          read_limit,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [2:0]          kind,
	output logic [7:0]          data,
	output logic [5:0]          count,
	output logic                last,
	input  lerb_pkg::ctrl_cmd_t ctl,
	output lerb_pkg::dp_status_t st
);

	logic [7:0]                      mem [lerb_pkg::RING_DEPTH];
	logic [7:0]                      rd_data_q;
	logic [lerb_pkg::IDX_W-1:0]      rd_addr;
	logic [lerb_pkg::IDX_W-1:0]      head_q;
	logic [lerb_pkg::IDX_W-1:0]      tail_q;
	logic [lerb_pkg::FILL_W-1:0]     fill_q;
	logic [lerb_pkg::FILL_W-1:0]     got_q;
	logic [lerb_pkg::RING_DEPTH-1:0] nl_vec_q;
	logic                            wait_q;
	logic                            echo_q;
	logic                            bs_hit_q;
	logic [7:0]                      char_q;
	logic [6:0]                      limit_q;
	logic                            out_valid_q;
	logic [2:0]                      kind_q;
	logic [7:0]                      data_q;
	logic [5:0]                      count_q;
	logic                            last_q;
	logic                            acc_typed;
	logic                            in_bs;

	assign acc_typed = ctl.accept && !cmd;
	assign in_bs     = (char_in == lerb_pkg::CODE_BS);

	// The read port runs ahead by one entry while popping, so a byte per cycle comes out while the output slot is free.
	assign rd_addr = ctl.pop ? lerb_pkg::idx_inc(tail_q) : tail_q;

	always_ff @(posedge clk) begin
		if (acc_typed && !in_bs && fill_q != lerb_pkg::FILL_W'(lerb_pkg::RING_DEPTH)) begin
			mem[head_q] <= char_in;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			got_q    <= '0;
			nl_vec_q <= '0;
			wait_q   <= 1'b0;
			echo_q   <= 1'b1;
			bs_hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				echo_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				got_q <= '0;
			end
			if (acc_typed) begin
				if (in_bs) begin
					bs_hit_q <= (fill_q != '0);
					if (fill_q != '0) begin
						head_q                            <= lerb_pkg::idx_dec(head_q);
						fill_q                            <= fill_q - lerb_pkg::FILL_W'(1);
						nl_vec_q[lerb_pkg::idx_dec(head_q)] <= 1'b0;
					end
				end else if (fill_q != lerb_pkg::FILL_W'(lerb_pkg::RING_DEPTH)) begin
					head_q           <= lerb_pkg::idx_inc(head_q);
					fill_q           <= fill_q + lerb_pkg::FILL_W'(1);
					nl_vec_q[head_q] <= (char_in == lerb_pkg::CODE_NL);
				end
			end
			if (ctl.pop) begin
				tail_q           <= lerb_pkg::idx_inc(tail_q);
				fill_q           <= fill_q - lerb_pkg::FILL_W'(1);
				nl_vec_q[tail_q] <= 1'b0;
				got_q            <= got_q + lerb_pkg::FILL_W'(1);
			end
			if (ctl.set_wait) begin
				wait_q <= 1'b1;
			end else if (ctl.clr_wait) begin
				wait_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			char_q  <= char_in;
			limit_q <= read_limit;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			kind_q  <= ctl.kind;
			last_q  <= ctl.last;
			data_q  <= (ctl.kind == lerb_pkg::KIND_ECHO)  ? char_q :
			           (ctl.kind == lerb_pkg::KIND_RBYTE) ? rd_data_q : 8'd0;
			count_q <= (ctl.kind == lerb_pkg::KIND_REND) ? 6'(got_q) : 6'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign count     = count_q;
	assign last      = last_q;

	always_comb begin
		st.slot_free  = !out_valid_q || out_ready;
		st.echo_on    = echo_q;
		st.is_bs      = (char_q == lerb_pkg::CODE_BS);
		st.is_nl      = (char_q == lerb_pkg::CODE_NL);
		st.bs_hit     = bs_hit_q;
		st.waiting    = wait_q;
		st.line_avail = |nl_vec_q;
		st.max_zero   = (limit_q <= 7'd1);
		st.pop_done   = (rd_data_q == lerb_pkg::CODE_NL) ||
		                (8'(got_q) + 8'd1 == 8'(limit_q - 7'd1));
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= lerb_pkg::RING_DEPTH)
		else $error("fill level beyond ring depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		((int'(tail_q) + int'(fill_q)) % lerb_pkg::RING_DEPTH) == int'(head_q))
		else $error("head, tail and fill level disagree");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (fill_q != '0) && (|nl_vec_q))
		else $error("pop without a stored line");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("result overwrites one not yet transferred");

endmodule

FILE: rtl/lerb_ctrl.sv
module lerb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  lerb_pkg::dp_status_t st,
	output lerb_pkg::ctrl_cmd_t  ctl
);

	lerb_pkg::ctrl_state_t state_q;
	lerb_pkg::ctrl_state_t state_d;
	logic                  need_echo;
	logic                  need_wake;

	assign need_echo = st.echo_on && (!st.is_bs || st.bs_hit);
	assign need_wake = !st.is_bs && st.is_nl && st.waiting;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lerb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.kind     = lerb_pkg::KIND_ECHO;
		case (state_q)
			lerb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = cmd ? lerb_pkg::ST_R_CHK : lerb_pkg::ST_T_ECHO;
				end
			end
			lerb_pkg::ST_T_ECHO: begin
				if (need_echo) begin
					if (st.slot_free) begin
						ctl.emit = 1'b1;
						ctl.kind = st.is_bs ? lerb_pkg::KIND_ERASE : lerb_pkg::KIND_ECHO;
						ctl.last = !need_wake;
						state_d  = need_wake ? lerb_pkg::ST_T_WAKE : lerb_pkg::ST_IDLE;
					end
				end else begin
					state_d = need_wake ? lerb_pkg::ST_T_WAKE : lerb_pkg::ST_IDLE;
				end
			end
			lerb_pkg::ST_T_WAKE: begin
				if (st.slot_free) begin
					ctl.emit     = 1'b1;
					ctl.kind     = lerb_pkg::KIND_WAKE;
					ctl.last     = 1'b1;
					ctl.clr_wait = 1'b1;
					state_d      = lerb_pkg::ST_IDLE;
				end
			end
			lerb_pkg::ST_R_CHK: begin
				if (!st.line_avail) begin
					if (st.slot_free) begin
						ctl.emit     = 1'b1;
						ctl.kind     = lerb_pkg::KIND_BLOCK;
						ctl.last     = 1'b1;
						ctl.set_wait = 1'b1;
						state_d      = lerb_pkg::ST_IDLE;
					end
				end else if (st.max_zero) begin
					state_d = lerb_pkg::ST_R_END;
				end else begin
					state_d = lerb_pkg::ST_R_POP;
				end
			end
			lerb_pkg::ST_R_POP: begin
				if (st.slot_free) begin
					ctl.emit = 1'b1;
					ctl.kind = lerb_pkg::KIND_RBYTE;
					ctl.pop  = 1'b1;
					if (st.pop_done) begin
						state_d = lerb_pkg::ST_R_END;
					end
				end
			end
			lerb_pkg::ST_R_END: begin
				if (st.slot_free) begin
					ctl.emit = 1'b1;
					ctl.kind = lerb_pkg::KIND_REND;
					ctl.last = 1'b1;
					state_d  = lerb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lerb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/line_edit_ring_buffer_top.sv
// Terminal line buffer for typed characters, with line reads.
// Input channel (in_valid/in_ready): cmd 0 carries a typed byte in char_in, cmd 1 asks
// for one line of at most read_limit-1 bytes. One item is taken at a time: in_ready is
// high only while no earlier item is still producing results.
// Output channel (out_valid/out_ready): a stream of results, each with kind, data and
// count; last marks the final result of an item. An item may also produce no result.
// The first result of a typed byte is registered after the controller passes from idle
// to its echo state; a read checks for a stored line, then returns one byte per cycle
// while the output slot is free, and a closing count. That rate is set by the single
// read port of the ring memory, which is read one entry ahead while popping.
// The output register lets the final result of an item wait for the receiver while the
// next item is transferred; while the receiver stalls, processing pauses with all
// state held and no result is lost. The echo_on register (cfg_we/cfg_wdata) is to be
// written by the user only while the block is idle; the block does not enforce this.
// Reset clears the ring to empty, the waiting-reader mark and the output, and sets echo
// on; the ring memory itself is not cleared, as only entries inside the fill are output.
module line_edit_ring_buffer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] char_in,
	input  logic [6:0] read_limit,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] data,
	output logic [5:0] count,
	output logic       last
);

	// Command and status between the sequencer and the ring datapath.
	lerb_pkg::ctrl_cmd_t  ctl;
	lerb_pkg::dp_status_t st;

	// The controller decides which results an item gives and in what order.
	lerb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st),
		.ctl      (ctl)
	);

	// The datapath holds the ring, its pointers and the output register.
	lerb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_in    (char_in),
		.read_limit (read_limit),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.kind       (kind),
		.data       (data),
		.count      (count),
		.last       (last),
		.ctl        (ctl),
		.st         (st)
	);

endmodule
